@@ src/png_scanline_unfilter_assert.svh @@
// assertion macros used by pngunf_checker
`ifndef PNG_SCANLINE_UNFILTER_ASSERT_SVH
`define PNG_SCANLINE_UNFILTER_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define PNGUNF_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("png unfilter check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define PNGUNF_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("png unfilter check failed");

`endif

@@ src/pngunf_pkg.sv @@
package pngunf_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 14;
    localparam int CFG_WIDTH_W = 11;
    localparam int HEIGHT_W    = 14;
    localparam int ROW_W       = 13;

    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_COLOR_MODE   = 2'd2;

    localparam logic [1:0] MODE_GRAY = 2'd0;
    localparam logic [1:0] MODE_RGB  = 2'd1;
    localparam logic [1:0] MODE_RGBA = 2'd2;

    localparam logic [2:0] FILT_NONE  = 3'd0;
    localparam logic [2:0] FILT_SUB   = 3'd1;
    localparam logic [2:0] FILT_UP    = 3'd2;
    localparam logic [2:0] FILT_AVG   = 3'd3;
    localparam logic [2:0] FILT_PAETH = 3'd4;

    localparam logic [HEIGHT_W-1:0] HEIGHT_LIMIT = 14'd8192;
    localparam logic [7:0]          OPAQUE       = 8'hFF;

    // one byte in flight between the sequencer and the reconstruction stage
    typedef struct packed {
        logic       is_filter;
        logic       skip;
        logic       emit;
        logic       bad;
        logic       use_up;
        logic [2:0] filter;
        logic [1:0] ch;
        logic       last_row;
        logic       last_img;
        logic [7:0] data;
    } pngunf_item_t;

    // index of the last channel of a pixel; mode 3 acts as rgba
    function automatic logic [1:0] chan_last(input logic [1:0] mode);
        logic [1:0] res;
        unique case (mode)
            MODE_GRAY: res = 2'd0;
            MODE_RGB:  res = 2'd2;
            default:   res = 2'd3;
        endcase
        return res;
    endfunction

endpackage

@@ src/pngunf_ram.sv @@
module pngunf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ src/pngunf_ctrl.sv @@
module pngunf_ctrl #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [pngunf_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [pngunf_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [7:0]                             raw_byte,
    input  logic                                   s1_adv,
    output logic                                   item_valid,
    output pngunf_pkg::pngunf_item_t               item,
    output logic [$clog2(MAX_WIDTH*4)-1:0]         item_addr,
    output logic                                   rd_en,
    output logic [$clog2(MAX_WIDTH*4)-1:0]         rd_addr,
    output logic                                   clearing,
    output logic [$clog2(MAX_WIDTH*4)-1:0]         clr_addr,
    output logic [1:0]                             mode
);

    localparam int ROW_STORE = MAX_WIDTH * 4;
    localparam int AW        = $clog2(ROW_STORE);
    localparam int CW        = $clog2(ROW_STORE + 1);
    localparam int WW        = $clog2(MAX_WIDTH + 1);

    logic [pngunf_pkg::CFG_WIDTH_W-1:0] width_reg;
    logic [pngunf_pkg::HEIGHT_W-1:0]    height_reg;
    logic [1:0]                         mode_reg;

    logic [CW-1:0]                  col_reg, col_next;
    logic [pngunf_pkg::ROW_W-1:0]   row_reg, row_next;
    logic [1:0]                     m3_reg, m3_next;
    logic [2:0]                     filt_reg, filt_next;
    logic                           failed_reg, failed_next;

    logic                           item_valid_reg;
    pngunf_pkg::pngunf_item_t       item_reg, item_next;
    logic [AW-1:0]                  addr_reg;

    logic                           clear_reg;
    logic [AW-1:0]                  clr_addr_reg;

    logic [WW-1:0]                  eff_w;
    logic [pngunf_pkg::HEIGHT_W-1:0] eff_h;
    logic [CW-1:0]                  row_len;
    logic [CW-1:0]                  col_m1;
    logic [1:0]                     last_ch;
    logic [1:0]                     cur_ch;
    logic                           row_end;
    logic                           img_end;
    logic                           accept;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= pngunf_pkg::CFG_WIDTH_W'(1);
            height_reg <= pngunf_pkg::HEIGHT_W'(1);
            mode_reg   <= pngunf_pkg::MODE_RGBA;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pngunf_pkg::CFG_IMAGE_WIDTH:
                    width_reg <= cfg_data[pngunf_pkg::CFG_WIDTH_W-1:0];
                pngunf_pkg::CFG_IMAGE_HEIGHT:
                    height_reg <= cfg_data;
                pngunf_pkg::CFG_COLOR_MODE:
                    mode_reg <= cfg_data[1:0];
                default:
                    ;
            endcase
        end
    end

    // row geometry from the registers, width clamped to what the store holds, height to HEIGHT_LIMIT
    always_comb
    begin
        if (width_reg == '0)
        begin
            eff_w = WW'(1);
        end
        else if (32'(width_reg) > MAX_WIDTH)
        begin
            eff_w = WW'(MAX_WIDTH);
        end
        else
        begin
            eff_w = WW'(width_reg);
        end

        if (height_reg == '0)
        begin
            eff_h = pngunf_pkg::HEIGHT_W'(1);
        end
        else if (height_reg > pngunf_pkg::HEIGHT_LIMIT)
        begin
            eff_h = pngunf_pkg::HEIGHT_LIMIT;
        end
        else
        begin
            eff_h = height_reg;
        end

        unique case (mode_reg)
            pngunf_pkg::MODE_GRAY: row_len = CW'(eff_w);
            pngunf_pkg::MODE_RGB:  row_len = CW'(eff_w) + (CW'(eff_w) << 1);
            default:               row_len = CW'(eff_w) << 2;
        endcase
    end

    assign last_ch = pngunf_pkg::chan_last(mode_reg);
    assign col_m1  = col_reg - CW'(1);
    assign row_end = (col_reg >= row_len);
    assign img_end = row_end && ((pngunf_pkg::HEIGHT_W'(row_reg) + 14'd1) >= eff_h);

    // channel of the byte from its place in the row under the current mode
    always_comb
    begin
        unique case (mode_reg)
            pngunf_pkg::MODE_GRAY: cur_ch = 2'd0;
            pngunf_pkg::MODE_RGB:  cur_ch = m3_reg;
            default:               cur_ch = col_m1[1:0];
        endcase
    end

    assign in_ready = !clear_reg && (!item_valid_reg || s1_adv);
    assign accept   = in_valid && in_ready;

    // sequencing of one accepted byte
    always_comb
    begin
        col_next    = col_reg;
        row_next    = row_reg;
        m3_next     = m3_reg;
        filt_next   = filt_reg;
        failed_next = failed_reg;

        item_next           = '0;
        item_next.data      = raw_byte;
        item_next.filter    = filt_reg;
        item_next.ch        = cur_ch;
        item_next.use_up    = (row_reg != '0);
        item_next.skip      = failed_reg;

        if (col_reg == '0)
        begin
            item_next.is_filter = 1'b1;
            col_next            = CW'(1);
            m3_next             = '0;
            if (!failed_reg)
            begin
                if (raw_byte > 8'(pngunf_pkg::FILT_PAETH))
                begin
                    failed_next    = 1'b1;
                    item_next.bad  = 1'b1;
                    item_next.emit = 1'b1;
                end
                else
                begin
                    filt_next = raw_byte[2:0];
                end
            end
        end
        else
        begin
            item_next.emit     = !failed_reg && (cur_ch == last_ch);
            item_next.last_row = row_end;
            item_next.last_img = img_end;
            m3_next            = (m3_reg == 2'd2) ? 2'd0 : m3_reg + 2'd1;
            if (row_end)
            begin
                col_next = '0;
                if (img_end)
                begin
                    row_next    = '0;
                    failed_next = 1'b0;
                end
                else
                begin
                    row_next = row_reg + pngunf_pkg::ROW_W'(1);
                end
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg        <= '0;
            row_reg        <= '0;
            m3_reg         <= '0;
            filt_reg       <= pngunf_pkg::FILT_NONE;
            failed_reg     <= 1'b0;
            item_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                col_reg    <= col_next;
                row_reg    <= row_next;
                m3_reg     <= m3_next;
                filt_reg   <= filt_next;
                failed_reg <= failed_next;
            end
            if (accept)
            begin
                item_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                item_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_next;
            addr_reg <= col_m1[AW-1:0];
        end
    end

    // zeroing sweep of the row store after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_reg    <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clear_reg)
        begin
            clr_addr_reg <= clr_addr_reg + AW'(1);
            if (clr_addr_reg == AW'(ROW_STORE - 1))
            begin
                clear_reg <= 1'b0;
            end
        end
    end

    assign item_valid = item_valid_reg;
    assign item       = item_reg;
    assign item_addr  = addr_reg;
    assign rd_en      = accept;
    assign rd_addr    = col_m1[AW-1:0];
    assign clearing   = clear_reg;
    assign clr_addr   = clr_addr_reg;
    assign mode       = mode_reg;

endmodule

@@ src/pngunf_recon.sv @@
module pngunf_recon (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     item_valid,
    input  pngunf_pkg::pngunf_item_t item,
    input  logic [1:0]               mode,
    input  logic [7:0]               up_byte,
    output logic                     s1_adv,
    output logic                     wr_en,
    output logic [7:0]               wr_data,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [7:0]               red,
    output logic [7:0]               green,
    output logic [7:0]               blue,
    output logic [7:0]               alpha,
    output logic                     last_in_row,
    output logic                     last_in_image,
    output logic                     bad_filter
);

    logic [31:0] left_reg;
    logic [31:0] upleft_reg;
    logic [23:0] pix_reg;
    logic [23:0] pix_next;

    logic        out_valid_reg;
    logic [7:0]  red_reg, green_reg, blue_reg, alpha_reg;
    logic        last_row_reg, last_img_reg, bad_reg;
    logic [7:0]  red_next, green_next, blue_next, alpha_next;

    logic [1:0]  last_ch;
    logic [7:0]  left;
    logic [7:0]  upleft;
    logic [7:0]  up;
    logic [7:0]  pred;
    logic [7:0]  paeth;
    logic [8:0]  avg_sum;
    logic [9:0]  pa, pb, pc;
    logic [7:0]  rec;

    function automatic logic [9:0] abs_diff(input logic [9:0] x, input logic [9:0] y);
        logic [9:0] d;
        d = x - y;
        return d[9] ? (10'd0 - d) : d;
    endfunction

    assign last_ch = pngunf_pkg::chan_last(mode);
    assign left    = 8'(left_reg >> {last_ch, 3'b000});
    assign upleft  = 8'(upleft_reg >> {last_ch, 3'b000});
    // first row of an image sees zeros above
    assign up      = item.use_up ? up_byte : 8'd0;

    assign avg_sum = {1'b0, left} + {1'b0, up};
    assign pa      = abs_diff({2'b00, up}, {2'b00, upleft});
    assign pb      = abs_diff({2'b00, left}, {2'b00, upleft});
    assign pc      = abs_diff({2'b00, left} + {2'b00, up}, {1'b0, upleft, 1'b0});

    always_comb
    begin
        if (pa <= pb && pa <= pc)
        begin
            paeth = left;
        end
        else if (pb <= pc)
        begin
            paeth = up;
        end
        else
        begin
            paeth = upleft;
        end

        case (item.filter)
            pngunf_pkg::FILT_SUB:   pred = left;
            pngunf_pkg::FILT_UP:    pred = up;
            pngunf_pkg::FILT_AVG:   pred = avg_sum[8:1];
            pngunf_pkg::FILT_PAETH: pred = paeth;
            default:                pred = 8'd0;
        endcase
    end

    assign rec = item.data + pred;

    always_comb
    begin
        pix_next = pix_reg;
        case (item.ch)
            2'd0:    pix_next[7:0]   = rec;
            2'd1:    pix_next[15:8]  = rec;
            2'd2:    pix_next[23:16] = rec;
            default: pix_next        = pix_reg;
        endcase

        if (item.bad)
        begin
            red_next   = 8'd0;
            green_next = 8'd0;
            blue_next  = 8'd0;
            alpha_next = 8'd0;
        end
        else if (last_ch == 2'd0)
        begin
            red_next   = rec;
            green_next = rec;
            blue_next  = rec;
            alpha_next = pngunf_pkg::OPAQUE;
        end
        else
        begin
            red_next   = pix_next[7:0];
            green_next = pix_next[15:8];
            blue_next  = pix_next[23:16];
            alpha_next = (last_ch == 2'd3) ? rec : pngunf_pkg::OPAQUE;
        end
    end

    // a byte that completes a pixel waits only while the output register is full and out_ready is low
    assign s1_adv  = item_valid && (!item.emit || !out_valid_reg || out_ready);
    assign wr_en   = s1_adv && !item.is_filter && !item.skip;
    assign wr_data = rec;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg      <= '0;
            upleft_reg    <= '0;
            pix_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_adv)
            begin
                if (item.is_filter)
                begin
                    left_reg   <= '0;
                    upleft_reg <= '0;
                    pix_reg    <= '0;
                end
                else if (!item.skip)
                begin
                    left_reg   <= {left_reg[23:0], rec};
                    upleft_reg <= {upleft_reg[23:0], up};
                    pix_reg    <= pix_next;
                end
            end
            if (s1_adv && item.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && item.emit)
        begin
            red_reg      <= red_next;
            green_reg    <= green_next;
            blue_reg     <= blue_next;
            alpha_reg    <= alpha_next;
            last_row_reg <= item.last_row;
            last_img_reg <= item.last_img;
            bad_reg      <= item.bad;
        end
    end

    assign out_valid     = out_valid_reg;
    assign red           = red_reg;
    assign green         = green_reg;
    assign blue          = blue_reg;
    assign alpha         = alpha_reg;
    assign last_in_row   = last_row_reg;
    assign last_in_image = last_img_reg;
    assign bad_filter    = bad_reg;

endmodule

@@ src/png_scanline_unfilter.sv @@
// png scanline reconstruction, one inflated byte per beat
// input channel: in_valid / in_ready with raw_byte; each row is a filter
//   byte followed by image_width * channels sample bytes
// output channel: out_valid / out_ready with one rgba pixel per beat, plus
//   last_in_row, last_in_image, and bad_filter for a filter byte above 4
// configuration: cfg_we writes cfg_data to register cfg_index at once
//   (0 image_width, 1 image_height, 2 color_mode); other indexes are ignored
// throughput: one byte per cycle while in_ready is high; the left-byte path
//   (select, add, paeth compare) is combinational and the row store is read
//   as a byte is accepted; a pixel's last byte passes one stage, then the
//   output register, before the pixel can be taken
// reset: counters and the output clear at once, then a sweep zeroes the
//   row store at one entry per cycle over its MAX_WIDTH*4 entries (4096 by
//   default), with in_ready low; configuration writes are taken throughout
// receiver stall: the output register holds its pixel; bytes that complete
//   no pixel keep moving through, and in_ready drops once a byte that
//   completes a pixel waits in the stage behind the full output register
module png_scanline_unfilter #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [pngunf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [pngunf_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [7:0]                         raw_byte,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [7:0]                         red,
    output logic [7:0]                         green,
    output logic [7:0]                         blue,
    output logic [7:0]                         alpha,
    output logic                               last_in_row,
    output logic                               last_in_image,
    output logic                               bad_filter
);

    localparam int ROW_STORE = MAX_WIDTH * 4;
    localparam int AW        = $clog2(ROW_STORE);

    pngunf_pkg::pngunf_item_t item;
    logic                     item_valid;
    logic [AW-1:0]            item_addr;
    logic                     rd_en;
    logic [AW-1:0]            rd_addr;
    logic                     clearing;
    logic [AW-1:0]            clr_addr;
    logic [1:0]               mode;
    logic                     s1_adv;
    logic                     wr_en;
    logic [7:0]               wr_data;
    logic [7:0]               up_byte;

    logic                     ram_we;
    logic [AW-1:0]            ram_waddr;
    logic [7:0]               ram_wdata;

    pngunf_ctrl #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .raw_byte   (raw_byte),
        .s1_adv     (s1_adv),
        .item_valid (item_valid),
        .item       (item),
        .item_addr  (item_addr),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .clearing   (clearing),
        .clr_addr   (clr_addr),
        .mode       (mode)
    );

    // the sweep owns the write port until it is done
    assign ram_we    = clearing || wr_en;
    assign ram_waddr = clearing ? clr_addr : item_addr;
    assign ram_wdata = clearing ? 8'd0 : wr_data;

    pngunf_ram #(
        .WIDTH (8),
        .DEPTH (ROW_STORE)
    ) u_row_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (up_byte)
    );

    pngunf_recon u_recon (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item          (item),
        .mode          (mode),
        .up_byte       (up_byte),
        .s1_adv        (s1_adv),
        .wr_en         (wr_en),
        .wr_data       (wr_data),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .red           (red),
        .green         (green),
        .blue          (blue),
        .alpha         (alpha),
        .last_in_row   (last_in_row),
        .last_in_image (last_in_image),
        .bad_filter    (bad_filter)
    );

endmodule

@@ src/pngunf_checker.sv @@
`include "png_scanline_unfilter_assert.svh"

module pngunf_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] red,
    input logic [7:0] green,
    input logic [7:0] blue,
    input logic [7:0] alpha,
    input logic       last_in_row,
    input logic       last_in_image,
    input logic       bad_filter
);

    // a stalled beat stays on the output
    `PNGUNF_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid)

    `PNGUNF_ASSERT_NXT(a_out_stable, out_valid && !out_ready,
        $stable(red) && $stable(green) && $stable(blue) && $stable(alpha))

    // the error beat carries no pixel and no row or image marks
    `PNGUNF_ASSERT_IMP(a_bad_zero, out_valid && bad_filter,
        red == 8'd0 && green == 8'd0 && blue == 8'd0 && alpha == 8'd0 &&
        !last_in_row && !last_in_image)

    // an image always ends on a row end
    `PNGUNF_ASSERT_IMP(a_img_row, out_valid && last_in_image, last_in_row)

endmodule

bind png_scanline_unfilter pngunf_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .red           (red),
    .green         (green),
    .blue          (blue),
    .alpha         (alpha),
    .last_in_row   (last_in_row),
    .last_in_image (last_in_image),
    .bad_filter    (bad_filter)
);

@@ tb/png_unfilter_checker.sv @@
`timescale 1ns / 100ps

module png_unfilter_checker #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [pngunf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [pngunf_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                               in_valid,
    input  logic                               in_ready,
    input  logic [7:0]                         raw_byte,
    input  logic                               out_valid,
    input  logic                               out_ready,
    input  logic [7:0]                         red,
    input  logic [7:0]                         green,
    input  logic [7:0]                         blue,
    input  logic [7:0]                         alpha,
    input  logic                               last_in_row,
    input  logic                               last_in_image,
    input  logic                               bad_filter,
    output int unsigned                        mismatch_count,
    output int unsigned                        pixels_owed
);

    localparam int ROW_STORE = MAX_WIDTH * 4;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       last_in_row;
        logic       last_in_image;
        logic       bad_filter;
    } pixel_t;

    pixel_t expected_pixels[$];

    logic [pngunf_pkg::CFG_WIDTH_W-1:0] width_reg;
    logic [pngunf_pkg::HEIGHT_W-1:0]    height_reg;
    logic [1:0]                         mode_reg;

    logic [7:0]  row_above [ROW_STORE];
    logic [31:0] recent_left;
    logic [31:0] recent_upleft;
    int unsigned column;
    int unsigned row;
    logic [2:0]  row_filter;
    logic [23:0] partial_pixel;
    logic        image_failed;

    function automatic int unsigned channels();
        int unsigned n;
        if (mode_reg == pngunf_pkg::MODE_GRAY)
        begin
            n = 1;
        end
        else if (mode_reg == pngunf_pkg::MODE_RGB)
        begin
            n = 3;
        end
        else
        begin
            n = 4;
        end
        return n;
    endfunction

    function automatic logic [7:0] paeth_predict(input logic [7:0] a, input logic [7:0] b,
                                                  input logic [7:0] c);
        int p;
        int pa;
        int pb;
        int pc;
        p  = int'(a) + int'(b) - int'(c);
        pa = p - int'(a);
        pb = p - int'(b);
        pc = p - int'(c);
        if (pa < 0) pa = -pa;
        if (pb < 0) pb = -pb;
        if (pc < 0) pc = -pc;
        if (pa <= pb && pa <= pc) return a;
        return (pb <= pc) ? b : c;
    endfunction

    // works out what one accepted byte does to the row state and the pixels owed
    task automatic rebuild_byte(input logic [7:0] b);
        int unsigned nch;
        int unsigned row_len;
        int unsigned rows;
        int unsigned idx;
        int unsigned ch;
        int unsigned sum;
        logic        row_end;
        logic        img_end;
        logic [7:0]  left;
        logic [7:0]  upleft;
        logic [7:0]  up;
        logic [7:0]  rebuilt;
        pixel_t      px;

        nch     = channels();
        row_len = ((width_reg == 0) ? 1
                   : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg)) * nch;
        rows    = (height_reg == 0) ? 1
                  : ((height_reg > pngunf_pkg::HEIGHT_LIMIT) ? pngunf_pkg::HEIGHT_LIMIT
                                                             : height_reg);
        px      = '0;

        if (column == 0)
        begin
            if (!image_failed)
            begin
                if (b > pngunf_pkg::FILT_PAETH)
                begin
                    image_failed = 1'b1;
                    px.bad_filter = 1'b1;
                    expected_pixels = {expected_pixels, px};
                end
                else
                begin
                    row_filter = b[2:0];
                end
            end
            recent_left   = '0;
            recent_upleft = '0;
            partial_pixel = '0;
            column        = 1;
        end
        else
        begin
            idx     = column - 1;
            row_end = (column >= row_len);
            img_end = row_end && (row + 1 >= rows);
            ch      = idx % nch;

            if (!image_failed)
            begin
                left   = recent_left[8*(nch-1) +: 8];
                upleft = recent_upleft[8*(nch-1) +: 8];
                up     = (row != 0 && idx < ROW_STORE) ? row_above[idx] : 8'h00;
                case (row_filter)
                    pngunf_pkg::FILT_SUB:   sum = b + left;
                    pngunf_pkg::FILT_UP:    sum = b + up;
                    pngunf_pkg::FILT_AVG:   sum = b + ((int'(left) + int'(up)) >> 1);
                    pngunf_pkg::FILT_PAETH: sum = b + paeth_predict(left, up, upleft);
                    default:                sum = b;
                endcase
                rebuilt = 8'(sum);
                if (idx < ROW_STORE) row_above[idx] = rebuilt;
                recent_left   = {recent_left[23:0], rebuilt};
                recent_upleft = {recent_upleft[23:0], up};

                if (ch < 3) partial_pixel[8*ch +: 8] = rebuilt;
                if (ch == nch - 1)
                begin
                    if (nch == 1)
                    begin
                        px.red   = rebuilt;
                        px.green = rebuilt;
                        px.blue  = rebuilt;
                        px.alpha = pngunf_pkg::OPAQUE;
                    end
                    else
                    begin
                        px.red   = partial_pixel[7:0];
                        px.green = partial_pixel[15:8];
                        px.blue  = partial_pixel[23:16];
                        px.alpha = (nch == 4) ? rebuilt : pngunf_pkg::OPAQUE;
                    end
                    px.last_in_row   = row_end;
                    px.last_in_image = img_end;
                    expected_pixels = {expected_pixels, px};
                end
            end

            if (row_end)
            begin
                column = 0;
                if (img_end)
                begin
                    row          = 0;
                    image_failed = 1'b0;
                end
                else
                begin
                    row = (row + 1) & 32'h1FFF;
                end
            end
            else
            begin
                column++;
            end
        end
    endtask

    task automatic compare_field(input string name, input logic [7:0] want,
                                 input logic [7:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        pixel_t want;
        if (!rst_n)
        begin
            width_reg     = 1;
            height_reg    = 1;
            mode_reg      = pngunf_pkg::MODE_RGBA;
            recent_left   = '0;
            recent_upleft = '0;
            column        = 0;
            row           = 0;
            row_filter    = pngunf_pkg::FILT_NONE;
            partial_pixel = '0;
            image_failed  = 1'b0;
            for (int k = 0; k < ROW_STORE; k++) row_above[k] = 8'h00;
            expected_pixels.delete();
            mismatch_count = 0;
            pixels_owed    = 0;
        end
        else
        begin
            // a byte taken at this edge still sees the old settings
            if (in_valid && in_ready) rebuild_byte(raw_byte);

            if (cfg_we)
            begin
                case (cfg_index)
                    pngunf_pkg::CFG_IMAGE_WIDTH:
                        width_reg  = cfg_data[pngunf_pkg::CFG_WIDTH_W-1:0];
                    pngunf_pkg::CFG_IMAGE_HEIGHT:
                        height_reg = cfg_data[pngunf_pkg::HEIGHT_W-1:0];
                    pngunf_pkg::CFG_COLOR_MODE:
                        mode_reg   = cfg_data[1:0];
                    default: ;
                endcase
            end

            if (out_valid && out_ready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    $error("unexpected pixel beat: rgba %0h %0h %0h %0h bad_filter %0b",
                           red, green, blue, alpha, bad_filter);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    compare_field("red", want.red, red);
                    compare_field("green", want.green, green);
                    compare_field("blue", want.blue, blue);
                    compare_field("alpha", want.alpha, alpha);
                    compare_field("last_in_row", want.last_in_row, last_in_row);
                    compare_field("last_in_image", want.last_in_image, last_in_image);
                    compare_field("bad_filter", want.bad_filter, bad_filter);
                end
            end

            pixels_owed = expected_pixels.size();
        end
    end

endmodule

@@ tb/tb_png_scanline_unfilter.sv @@
`timescale 1ns / 100ps

module tb_png_scanline_unfilter;

    localparam int MAX_WIDTH   = 1024;
    localparam int ITEM_TARGET = 1150;
    localparam int HOLD_AT     = 300;
    localparam int HOLD_CYCLES = 400;
    localparam int STALL_LIMIT = 20000;
    localparam int SETTLE      = 8;

    localparam logic [pngunf_pkg::CFG_INDEX_W-1:0] CFG_SPARE = 2'd3;
    localparam logic [7:0] FILT_BAD = 8'(pngunf_pkg::FILT_PAETH) + 8'd1;

    logic                               clk       = 1'b0;
    logic                               rst_n     = 1'b0;
    logic                               cfg_we    = 1'b0;
    logic [pngunf_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [pngunf_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                               in_valid  = 1'b0;
    logic [7:0]                         raw_byte  = '0;
    logic                               out_ready = 1'b0;
    logic                               in_ready;
    logic                               out_valid;
    logic [7:0]                         red;
    logic [7:0]                         green;
    logic [7:0]                         blue;
    logic [7:0]                         alpha;
    logic                               last_in_row;
    logic                               last_in_image;
    logic                               bad_filter;
    int unsigned                        mismatch_count;
    int unsigned                        pixels_owed;

    int unsigned sent_count = 0;
    int unsigned burst_left = 1;

    // stream position as the block counts it, so filter bytes land on row starts
    logic [pngunf_pkg::CFG_WIDTH_W-1:0] cur_width  = 1;
    logic [pngunf_pkg::HEIGHT_W-1:0]    cur_height = 1;
    logic [1:0]                         cur_mode   = pngunf_pkg::MODE_RGBA;
    int unsigned                        pos_column = 0;
    int unsigned                        pos_row    = 0;

    int unsigned hold_left   = 0;
    logic        hold_done   = 1'b0;
    int unsigned rcv_cycle   = 0;
    int unsigned quiet_count = 0;

    always #6 clk = ~clk;

    png_scanline_unfilter #(
        .MAX_WIDTH(MAX_WIDTH)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .raw_byte      (raw_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .red           (red),
        .green         (green),
        .blue          (blue),
        .alpha         (alpha),
        .last_in_row   (last_in_row),
        .last_in_image (last_in_image),
        .bad_filter    (bad_filter)
    );

    png_unfilter_checker #(
        .MAX_WIDTH(MAX_WIDTH)
    ) pixel_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .raw_byte       (raw_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .red            (red),
        .green          (green),
        .blue           (blue),
        .alpha          (alpha),
        .last_in_row    (last_in_row),
        .last_in_image  (last_in_image),
        .bad_filter     (bad_filter),
        .mismatch_count (mismatch_count),
        .pixels_owed    (pixels_owed)
    );

    // receiver: one long hold-off once the stream is going, otherwise a rotating pattern
    always @(negedge clk)
    begin
        rcv_cycle <= rcv_cycle + 1;
        if (hold_left != 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (!hold_done && sent_count >= HOLD_AT)
        begin
            out_ready <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else
        begin
            case ((rcv_cycle / 64) % 4)
                0:       out_ready <= 1'b1;
                1:       out_ready <= ($urandom_range(0, 3) != 0);
                2:       out_ready <= ($urandom_range(0, 3) == 0);
                default: out_ready <= ((rcv_cycle % 5) >= 2);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
        begin
            quiet_count <= 0;
        end
        else if (quiet_count >= STALL_LIMIT)
        begin
            $display("png_scanline_unfilter: mismatch");
            $finish;
        end
        else
        begin
            quiet_count <= quiet_count + 1;
        end
    end

    function automatic int unsigned row_span();
        int unsigned w;
        int unsigned nch;
        w   = (cur_width == 0) ? 1 : ((cur_width > MAX_WIDTH) ? MAX_WIDTH : cur_width);
        nch = (cur_mode == pngunf_pkg::MODE_GRAY) ? 1
              : ((cur_mode == pngunf_pkg::MODE_RGB) ? 3 : 4);
        return w * nch;
    endfunction

    function automatic int unsigned image_rows();
        return (cur_height == 0) ? 1
               : ((cur_height > pngunf_pkg::HEIGHT_LIMIT) ? pngunf_pkg::HEIGHT_LIMIT
                                                          : cur_height);
    endfunction

    function automatic logic [7:0] pick_byte(input bit noisy);
        int unsigned roll;
        roll = $urandom_range(0, 39);
        if (noisy) return 8'($urandom);
        if (pos_column == 0)
        begin
            if (roll == 0) return 8'($urandom_range(FILT_BAD, 255));
            return 8'($urandom_range(pngunf_pkg::FILT_NONE, pngunf_pkg::FILT_PAETH));
        end
        if (roll < 3) return 8'h00;
        if (roll < 6) return 8'hFF;
        return 8'($urandom);
    endfunction

    // called at a falling edge, returns at a falling edge
    task automatic send_byte(input logic [7:0] b);
        raw_byte <= b;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sent_count++;
        if (pos_column == 0)
        begin
            pos_column = 1;
        end
        else if (pos_column >= row_span())
        begin
            pos_column = 0;
            pos_row    = (pos_row + 1 >= image_rows()) ? 0 : pos_row + 1;
        end
        else
        begin
            pos_column++;
        end
        burst_left--;
        @(negedge clk);
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(0, 7) == 0 ? 20 : $urandom_range(1, 5)) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 30);
        end
    endtask

    task automatic write_regs(input int unsigned width, input int unsigned height,
                              input logic [1:0] mode, input bit spare);
        cfg_we     <= 1'b1;
        cfg_index  <= pngunf_pkg::CFG_IMAGE_WIDTH;
        cfg_data   <= {3'($urandom), width[10:0]};
        cur_width  = width[10:0];
        @(negedge clk);
        cfg_index  <= pngunf_pkg::CFG_IMAGE_HEIGHT;
        cfg_data   <= height[13:0];
        cur_height = height[13:0];
        @(negedge clk);
        cfg_index  <= pngunf_pkg::CFG_COLOR_MODE;
        cfg_data   <= {12'($urandom), mode};
        cur_mode   = mode;
        @(negedge clk);
        if (spare)
        begin
            // unused index, must leave every setting alone
            cfg_index <= CFG_SPARE;
            cfg_data  <= 14'($urandom);
            @(negedge clk);
        end
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // drop valid, wait for every owed pixel, then let the pipeline empty
    task automatic settle();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pixels_owed != 0) @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    initial
    begin
        logic [7:0]  opening [24];
        int unsigned phase_no;
        int unsigned width;
        int unsigned height;
        int unsigned full;
        int unsigned count;
        int unsigned roll;
        bit          noisy;

        // gray 2x4: every filter with data above and to the left, then a bad
        // filter part way through the second image
        opening = '{pngunf_pkg::FILT_NONE,  8'h00, 8'hFF,
                    pngunf_pkg::FILT_SUB,   8'hFF, 8'h01,
                    pngunf_pkg::FILT_UP,    8'h80, 8'h80,
                    pngunf_pkg::FILT_AVG,   8'hFF, 8'hFF,
                    pngunf_pkg::FILT_PAETH, 8'h10, 8'hF0,
                    pngunf_pkg::FILT_PAETH, 8'h7F, 8'h81,
                    FILT_BAD,               8'hAA, 8'h55,
                    8'h00,                  8'h01, 8'h02};

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        write_regs(2, 4, pngunf_pkg::MODE_GRAY, 1'b0);
        foreach (opening[k]) send_byte(opening[k]);
        settle();

        phase_no = 0;
        while (sent_count < ITEM_TARGET)
        begin
            if (phase_no == 0)
            begin
                // one full row at the widest setting and a bit of the next, image left open
                write_regs(2047, 16383, pngunf_pkg::MODE_GRAY, 1'b1);
                count = row_span() + 1 + $urandom_range(1, 40);
                noisy = 1'b0;
            end
            else
            begin
                roll  = $urandom_range(0, 11);
                width = (roll == 0) ? 0 : (roll == 1) ? 1 : (roll == 2) ? $urandom_range(9, 2047)
                      : $urandom_range(1, 8);
                roll   = $urandom_range(0, 11);
                height = (roll == 0) ? 0 : (roll == 1) ? 16383 : (roll == 2) ? 8192
                       : $urandom_range(1, 4);
                write_regs(width, height, 2'($urandom), $urandom_range(0, 7) == 0);
                full  = image_rows() * (row_span() + 1) * $urandom_range(1, 3);
                count = full;
                if (full > 150 || $urandom_range(0, 3) == 0)
                    count = $urandom_range(1, (full > 150) ? 150 : full);
                if (count > ITEM_TARGET - sent_count)
                    count = ITEM_TARGET - sent_count;
                noisy = ($urandom_range(0, 9) == 0);
            end
            repeat (count) send_byte(pick_byte(noisy));
            settle();
            phase_no++;
        end

        repeat (SETTLE) @(negedge clk);
        if (mismatch_count == 0)
            $display("png_scanline_unfilter: match");
        else
            $display("png_scanline_unfilter: mismatch");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+src
src/pngunf_pkg.sv
src/pngunf_ram.sv
src/pngunf_ctrl.sv
src/pngunf_recon.sv
src/png_scanline_unfilter.sv
src/pngunf_checker.sv
tb/png_unfilter_checker.sv
tb/tb_png_scanline_unfilter.sv
